### rtl/core/ktpw_pkg.sv
// ----------------------------------------------------------------------------
// ktpw_pkg
// shared types and constants of the keyed table generator
// ----------------------------------------------------------------------------
package ktpw_pkg;

	localparam logic [31:0] LEFT_MUL = 32'h9e3779b7;
	localparam logic [31:0] MIX_MUL  = 32'h06a0dd9b;

	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] key;
	} req_t;

	typedef struct packed {
		logic [31:0] word;
		logic        status;
	} rsp_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] w;
		w = {v, v} << s;
		return w[63:32];
	endfunction

endpackage

### rtl/core/ktpw_if.sv
// ----------------------------------------------------------------------------
// ktpw_req_if / ktpw_rsp_if
// valid/ready channels of the keyed table generator
// ----------------------------------------------------------------------------
interface ktpw_req_if import ktpw_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ktpw_rsp_if import ktpw_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ktpw_step.sv
// ----------------------------------------------------------------------------
// ktpw_step
// shared step unit: one generator step from two registered table words
// ----------------------------------------------------------------------------
module ktpw_step import ktpw_pkg::*; (
	input  logic [31:0] m6,
	input  logic [31:0] m7,
	input  logic [31:0] k,
	input  logic [31:0] a,
	input  logic [7:0]  d,
	output logic [31:0] na,
	output logic [31:0] c
);
	logic [31:0] o;
	logic [31:0] b;
	logic [31:0] dv;

	always_comb begin
		dv = {24'd0, d};
		o  = (m6 << 6) ^ (m7 << 7);
		na = (dv ^ o) ^ (k + a);
		b  = (k + na) ^ (o + dv);
		c  = rotl32((na >> 13) ^ na, b[4:0]);
	end
endmodule

### rtl/core/keyed_table_prng_warmup_core.sv
// ----------------------------------------------------------------------------
// keyed_table_prng_warmup_core
// keyed two-table word generator with warm-up pass
// ----------------------------------------------------------------------------
// req carries req_type and key; rsp carries word and status.
// A seed transaction gives no response. It fills both tables (one multiply
// pair per entry through the fill path), runs the warm-up pass (255 steps:
// read, step, swap write), then folds left into mix while building the
// parity hash (256 entries: read, write back). req ready is low meanwhile.
// A draw reads two table words from the mix memory, then the shared step
// unit computes the result, which is registered and shown in ST_OUT. A new
// draw is accepted only after the previous response has been taken.
// An exhausted or unseeded draw returns word 0, status 1 in the cycle after
// acceptance; here too the next request waits for the response to be taken.
// While rsp is stalled the result holds and req ready stays low.
// Reset clears the sequencer and the generator state; table contents are
// undefined until the first seed and are never used before it.
// ----------------------------------------------------------------------------
module keyed_table_prng_warmup_core import ktpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ktpw_req_if.sink    req,
	ktpw_rsp_if.source  rsp
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_FILL  = 8'b00000010,
		ST_WRD   = 8'b00000100,
		ST_WSTEP = 8'b00001000,
		ST_WSWP  = 8'b00010000,
		ST_FOLD  = 8'b00100000,
		ST_DRAW  = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t      state_q;
	logic [31:0] key_q, cons_q, acc_q, hash_q;
	logic [7:0]  d_q, step_q, idx_q;
	logic        fold_rd_q;
	logic [31:0] left_mem [256];
	logic [31:0] mix_mem [256];
	logic [31:0] m6_q, m7_q, li_q, ld_q;
	rsp_t        rsp_q;

	logic [31:0] k_sel, a_sel, na, c;
	logic [31:0] fill_base, fill_l, fill_m;
	logic [7:0]  i6, i7, dn;

	assign k_sel = (state_q == ST_DRAW) ? cons_q : key_q;
	assign a_sel = acc_q;
	assign i6    = idx_q + 8'd6;
	assign i7    = idx_q + 8'd7;
	assign dn    = c[7:0];

	ktpw_step u_step (
		.m6(m6_q), .m7(m7_q), .k(k_sel), .a(a_sel), .d(d_q), .na(na), .c(c)
	);

	always_comb begin
		fill_base = {24'd0, idx_q} + key_q;
		fill_l = rotl32(fill_base * LEFT_MUL, idx_q[4:0] ^ key_q[4:0]);
		fill_m = rotl32(fill_base * MIX_MUL, idx_q[4:0] ^ key_q[4:0]);
	end

	assign req.ready = (state_q == ST_IDLE) && !rsp.valid;
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data  = rsp_q;

	// memory ports
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FILL: begin
				left_mem[idx_q] <= fill_l;
				mix_mem[idx_q]  <= fill_m;
			end
			ST_WSWP: begin
				if (idx_q >= 8'd2) begin
					left_mem[idx_q] <= ld_q;
					left_mem[d_q]   <= li_q;
				end
			end
			ST_FOLD: begin
				if (fold_rd_q)
					mix_mem[idx_q] <= m6_q ^ li_q;
			end
			default: ;
		endcase
		if (state_q == ST_FOLD) begin
			m6_q <= mix_mem[idx_q];
			li_q <= left_mem[idx_q];
		end else begin
			m6_q <= mix_mem[i6];
			m7_q <= mix_mem[i7];
			li_q <= left_mem[idx_q];
			ld_q <= left_mem[dn];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			key_q     <= '0;
			cons_q    <= '0;
			acc_q     <= '0;
			hash_q    <= '0;
			d_q       <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			fold_rd_q <= 1'b0;
			rsp_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						if (req.data.req_type == REQ_SEED) begin
							key_q <= req.data.key;
							idx_q <= '0;
							state_q <= ST_FILL;
						end else if (step_q == 8'd0) begin
							rsp_q <= '{word: 32'd0, status: STATUS_EMPTY};
							state_q <= ST_OUT;
						end else begin
							idx_q <= step_q;
							state_q <= ST_DRAW;
						end
					end
				end
				ST_FILL: begin
					idx_q <= idx_q + 8'd1;
					if (idx_q == 8'hFF) begin
						idx_q <= 8'hFF;
						acc_q <= key_q;
						d_q <= '0;
						state_q <= ST_WRD;
					end
				end
				// wait state for the registered mix reads
				ST_WRD: state_q <= ST_WSTEP;
				ST_WSTEP: begin
					acc_q <= na;
					d_q <= dn;
					state_q <= ST_WSWP;
				end
				ST_WSWP: begin
					if (idx_q == 8'd1) begin
						idx_q <= '0;
						hash_q <= '0;
						fold_rd_q <= 1'b0;
						state_q <= ST_FOLD;
					end else begin
						idx_q <= idx_q - 8'd1;
						state_q <= ST_WRD;
					end
				end
				// read at idx, write back in the following cycle at the same idx
				ST_FOLD: begin
					if (!fold_rd_q) begin
						fold_rd_q <= 1'b1;
					end else begin
						fold_rd_q <= 1'b0;
						hash_q <= hash_q ^ ((m6_q ^ li_q) << idx_q[7:5]);
						if (idx_q == 8'hFF) begin
							cons_q <= hash_q ^ ((m6_q ^ li_q) << idx_q[7:5]);
							acc_q <= hash_q ^ ((m6_q ^ li_q) << idx_q[7:5]);
							d_q <= '0;
							step_q <= 8'hFF;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 8'd1;
						end
					end
				end
				ST_DRAW: begin
					if (fold_rd_q) begin
						fold_rd_q <= 1'b0;
						acc_q <= na;
						d_q <= dn;
						step_q <= step_q - 8'd1;
						rsp_q <= '{word: c, status: STATUS_OK};
						state_q <= ST_OUT;
					end else begin
						fold_rd_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (rsp.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/ktpw_checker.sv
// ----------------------------------------------------------------------------
// ktpw_checker
// port-level checks of the keyed table generator
// ----------------------------------------------------------------------------
module ktpw_checker import ktpw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	// no new transaction while a response waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("req ready while rsp pending");

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled rsp changed");

	// exhausted responses carry a zero word
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.word == 32'd0)
		else $error("exhausted word not zero");

	// in the cycle after an accepted request, rsp valid and req ready are never both high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid || !req_ready)
		else $error("bad response timing");
endmodule

bind keyed_table_prng_warmup_core ktpw_checker u_ktpw_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
